### rtl/fwdh_pkg.sv
// Shared types and codes for the freeze watchdog heartbeat unit.
// No dependencies; imported by the engine and the top level.
`default_nettype none

package fwdh_pkg;

    // request codes carried on the input tuser
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_KICK  = 2'd1;
    localparam logic [1:0] REQ_POLL  = 2'd2;
    localparam logic [1:0] REQ_STOP  = 2'd3;

    // event codes carried on the output tuser
    localparam logic [1:0] EV_STARTED   = 2'd0;
    localparam logic [1:0] EV_BEAT      = 2'd1;
    localparam logic [1:0] EV_RECOVERED = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_PERIOD    = 2'd1;
    localparam logic [1:0] CFG_CAPTURE   = 2'd2;

    // configuration reset values
    localparam logic [31:0] THRESHOLD_RESET = 32'd1000;
    localparam logic [31:0] PERIOD_RESET    = 32'd1000;
    localparam logic [1:0]  CAPTURE_RESET   = 2'd0;

    // capture_mode bits
    localparam int CAP_ON_START = 0;
    localparam int CAP_ON_BEAT  = 1;

    typedef struct packed {
        logic [31:0] freeze_threshold;
        logic [31:0] heartbeat_period;
        logic [1:0]  capture_mode;
    } fwdh_cfg_t;

    typedef struct packed {
        logic        capture_request;
        logic [31:0] beat_index;
        logic [31:0] elapsed_ms;
        logic [31:0] freeze_number;
        logic [1:0]  event_kind;
    } fwdh_event_t;

endpackage

`default_nettype wire

### rtl/fwdh_engine.sv
// Watchdog state and event decision for one request per cycle, taken while item_fire is high.
// Depends on fwdh_pkg for codes, configuration and event types.
`default_nettype none

module fwdh_engine #(
    parameter int TIME_WIDTH = 32
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       item_fire,
    input  wire  [1:0]                req_type,
    input  wire  [31:0]               now_ms,
    input  fwdh_pkg::fwdh_cfg_t       cfg,
    output logic                      ev_valid,
    output fwdh_pkg::fwdh_event_t     ev
);
    import fwdh_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    logic                  armed_reg, armed_next;
    logic                  frozen_reg, frozen_next;
    logic [TIME_WIDTH-1:0] last_kick_reg, last_kick_next;
    logic [TIME_WIDTH-1:0] begin_reg, begin_next;
    logic [TIME_WIDTH-1:0] last_beat_reg, last_beat_next;
    logic [31:0]           freeze_cnt_reg, freeze_cnt_next;
    logic [31:0]           beat_cnt_reg, beat_cnt_next;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] lag;
    logic [TIME_WIDTH-1:0] since_beat;
    logic [TIME_WIDTH-1:0] since_begin;
    logic                  over;
    logic                  beat_due;

    // time differences: since_beat and since_begin modulo 2^TIME_WIDTH, lag clamped at zero
    always_comb begin
        now_t       = TIME_WIDTH'(now_ms);
        lag         = (now_t > last_kick_reg) ? (now_t - last_kick_reg) : '0;
        since_beat  = now_t - last_beat_reg;
        since_begin = now_t - begin_reg;
        over        = CMP_W'(lag) >= CMP_W'(cfg.freeze_threshold);
        beat_due    = CMP_W'(since_beat) >= CMP_W'(cfg.heartbeat_period);
    end

    // request decode and next state
    always_comb begin
        armed_next      = armed_reg;
        frozen_next     = frozen_reg;
        last_kick_next  = last_kick_reg;
        begin_next      = begin_reg;
        last_beat_next  = last_beat_reg;
        freeze_cnt_next = freeze_cnt_reg;
        beat_cnt_next   = beat_cnt_reg;
        ev_valid        = 1'b0;
        ev.event_kind      = EV_RECOVERED;
        ev.freeze_number   = freeze_cnt_reg;
        ev.elapsed_ms      = 32'(since_begin);
        ev.beat_index      = beat_cnt_reg;
        ev.capture_request = 1'b0;

        unique case (req_type)
            REQ_START: begin
                if (!armed_reg) begin
                    armed_next      = 1'b1;
                    frozen_next     = 1'b0;
                    last_kick_next  = now_t;
                    begin_next      = '0;
                    last_beat_next  = '0;
                    freeze_cnt_next = '0;
                    beat_cnt_next   = '0;
                end
            end
            REQ_KICK: begin
                last_kick_next = now_t;
            end
            REQ_STOP: begin
                if (armed_reg) begin
                    armed_next = 1'b0;
                    if (frozen_reg) begin
                        frozen_next = 1'b0;
                        ev_valid    = 1'b1;
                    end
                end
            end
            REQ_POLL: begin
                if (armed_reg) begin
                    if (!frozen_reg && over) begin
                        // freeze begins at the last kick
                        frozen_next        = 1'b1;
                        begin_next         = last_kick_reg;
                        freeze_cnt_next    = freeze_cnt_reg + 32'd1;
                        beat_cnt_next      = '0;
                        last_beat_next     = now_t;
                        ev_valid           = 1'b1;
                        ev.event_kind      = EV_STARTED;
                        ev.freeze_number   = freeze_cnt_reg + 32'd1;
                        ev.elapsed_ms      = 32'(lag);
                        ev.beat_index      = '0;
                        ev.capture_request = cfg.capture_mode[CAP_ON_START];
                    end else if (frozen_reg && over) begin
                        if (beat_due) begin
                            beat_cnt_next      = beat_cnt_reg + 32'd1;
                            last_beat_next     = now_t;
                            ev_valid           = 1'b1;
                            ev.event_kind      = EV_BEAT;
                            ev.beat_index      = beat_cnt_reg + 32'd1;
                            ev.capture_request = cfg.capture_mode[CAP_ON_BEAT];
                        end
                    end else if (frozen_reg) begin
                        // lag fell below threshold
                        frozen_next    = 1'b0;
                        begin_next     = '0;
                        last_beat_next = '0;
                        beat_cnt_next  = '0;
                        ev_valid       = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // state registers, updated once per processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg      <= 1'b0;
            frozen_reg     <= 1'b0;
            last_kick_reg  <= '0;
            begin_reg      <= '0;
            last_beat_reg  <= '0;
            freeze_cnt_reg <= '0;
            beat_cnt_reg   <= '0;
        end else if (item_fire) begin
            armed_reg      <= armed_next;
            frozen_reg     <= frozen_next;
            last_kick_reg  <= last_kick_next;
            begin_reg      <= begin_next;
            last_beat_reg  <= last_beat_next;
            freeze_cnt_reg <= freeze_cnt_next;
            beat_cnt_reg   <= beat_cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/freeze_watchdog_heartbeat_unit.sv
// Top level of the freeze watchdog heartbeat unit: stream ports,
// configuration registers, input and result registers. Uses fwdh_pkg, fwdh_engine.
//
// Usage: each input beat carries a request (start, kick, poll, stop) on
// s_tuser and a millisecond timestamp on s_tdata. A beat yields zero or one
// event beat on the m_ side: freeze started, heartbeat or recovered, with
// the freeze number, elapsed time, heartbeat index and a capture flag.
// Registers are written over the cfg_ channel (index 0 threshold,
// 1 heartbeat period, 2 capture mode); cfg_ready is always high and writes
// belong in idle periods.
// Flow: an accepted beat lands in the input register, is decided by the
// engine once the result register is free, and its event is registered in
// the result register, which drives m_. Throughput: one beat per cycle while
// the receiver accepts events; the engine updates its state once per beat.
// Reset (aresetn low, synchronous) disarms the block, clears all watchdog
// state and restores the register defaults. When the receiver stalls, the
// result register holds its event, the input register fills and s_tready
// drops; no beat is lost.
`default_nettype none

module freeze_watchdog_heartbeat_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  wire          aclk,
    input  wire          aresetn,
    // request channel
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [31:0]  s_tdata,   // [31:0] now_ms
    input  wire  [1:0]   s_tuser,   // [1:0] req_type
    // event channel
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [103:0] m_tdata,   // [31:0] freeze_number, [63:32] elapsed_ms,
                                    // [95:64] beat_index, [96] capture_request
    output logic [1:0]   m_tuser,   // [1:0] event_kind
    // configuration write channel
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [1:0]   cfg_index,
    input  wire  [31:0]  cfg_data
);
    import fwdh_pkg::*;

    fwdh_cfg_t   cfg_reg;
    logic        in_valid_reg;
    logic [1:0]  in_req_reg;
    logic [31:0] in_now_reg;
    logic        out_valid_reg;
    fwdh_event_t out_ev_reg;

    logic        out_free;
    logic        advance;
    logic        ev_valid;
    fwdh_event_t ev;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.freeze_threshold <= THRESHOLD_RESET;
            cfg_reg.heartbeat_period <= PERIOD_RESET;
            cfg_reg.capture_mode     <= CAPTURE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_THRESHOLD: cfg_reg.freeze_threshold <= cfg_data;
                CFG_PERIOD:    cfg_reg.heartbeat_period <= cfg_data;
                CFG_CAPTURE:   cfg_reg.capture_mode     <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg <= s_tuser;
            in_now_reg <= s_tdata;
        end
    end

    fwdh_engine #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (advance),
        .req_type  (in_req_reg),
        .now_ms    (in_now_reg),
        .cfg       (cfg_reg),
        .ev_valid  (ev_valid),
        .ev        (ev)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= ev_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ev_valid) begin
            out_ev_reg <= ev;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ev_reg.event_kind;
    assign m_tdata  = {7'd0, out_ev_reg.capture_request, out_ev_reg.beat_index,
                       out_ev_reg.elapsed_ms, out_ev_reg.freeze_number};

endmodule

`default_nettype wire
